>>> hdl/deq_pkg.sv
package deq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;
    localparam int FILL_W    = 5;
    localparam int FUNC_W    = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_REAR  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_REAR   = 3'd3,
        FN_LIST       = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_LIST
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [WORD_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [WORD_W-1:0] value_out;
        logic                     last;
        logic [FILL_W-1:0]        fill_count;
    } t_out_item;

    // Pointer updates requested by the sequencer
    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
    } t_ptr_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_ptr_stat;

endpackage

>>> hdl/deq_in_if.sv
interface deq_in_if
    import deq_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/deq_out_if.sv
interface deq_out_if
    import deq_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/deq_mem.sv
module deq_mem
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/deq_ptr.sv
module deq_ptr
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ptr_cmd      i_cmd,
    input  logic [AW-1:0] i_walk_off,
    output t_ptr_stat     o_stat,
    output logic [CW-1:0] o_count,
    output logic [AW-1:0] o_head,
    output logic [AW-1:0] o_push_front_slot,
    output logic [AW-1:0] o_push_rear_slot,
    output logic [AW-1:0] o_pop_rear_slot,
    output logic [AW-1:0] o_walk_slot
);

    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_head;
    logic [CW-1:0] n_count;
    logic [AW-1:0] head_inc;

    // Slot that lies off places past the head, wrapped once
    function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign head_inc          = slot_at(r_head, CW'(1));
    assign o_push_front_slot = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign o_push_rear_slot  = slot_at(r_head, r_count);
    assign o_pop_rear_slot   = slot_at(r_head, r_count - CW'(1));
    assign o_walk_slot       = slot_at(r_head, CW'(i_walk_off));
    assign o_head            = r_head;
    assign o_count           = r_count;
    assign o_stat.full       = (r_count == CW'(DEPTH));
    assign o_stat.empty      = (r_count == '0);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.push_front) begin
            n_head  = o_push_front_slot;
            n_count = r_count + CW'(1);
        end else if (i_cmd.push_rear) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop_front) begin
            n_head  = head_inc;
            n_count = r_count - CW'(1);
        end else if (i_cmd.pop_rear) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

endmodule

>>> hdl/double_ended_queue_top.sv
// Bounded double-ended queue of signed 32-bit words, DEPTH entries deep, kept
// as a circular buffer in one synchronous RAM with a head pointer and a count.
// Each transfer on i_in names an operation (push front, push rear, pop front,
// pop rear, list); each operation answers with one transfer on o_out, except
// a listing of a non-empty queue, which answers with one transfer per held
// word from front to rear, last set on the final one. Pushes to a full queue
// and pops from an empty one change nothing and answer with a refusal status.
// Pushes, refusals and unused codes load the output register on accept; a
// pop reads the RAM on accept and loads the word in S_POP; a listing loads its
// words in S_LIST, one word per cycle unless stalled, through the single RAM
// read port. A finished result sits in the output register, so the next item
// can be taken in the same cycle that the result is being transferred out.
// Stalls on o_out hold the sequencer and the RAM read data in place.
module double_ended_queue_top
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    deq_in_if.sink    i_in,
    deq_out_if.source o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] n_idx;
    logic          r_out_valid;
    t_out_item     r_out;
    t_out_item     n_out;
    logic          out_load;
    logic          out_free;
    logic          in_ready;

    t_ptr_cmd      ptr_cmd;
    t_ptr_stat     ptr_stat;
    logic [CW-1:0] count;
    logic [AW-1:0] head;
    logic [AW-1:0] push_front_slot;
    logic [AW-1:0] push_rear_slot;
    logic [AW-1:0] pop_rear_slot;
    logic [AW-1:0] walk_slot;
    logic [AW-1:0] walk_off;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    logic [CW+FILL_W-1:0] cnt_ext;
    logic [CW+FILL_W-1:0] cnt_inc_ext;
    logic [FILL_W-1:0]    fill_now;
    logic [FILL_W-1:0]    fill_inc;
    logic                 walk_last;

    deq_ptr #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ptr (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (ptr_cmd),
        .i_walk_off        (walk_off),
        .o_stat            (ptr_stat),
        .o_count           (count),
        .o_head            (head),
        .o_push_front_slot (push_front_slot),
        .o_push_rear_slot  (push_rear_slot),
        .o_pop_rear_slot   (pop_rear_slot),
        .o_walk_slot       (walk_slot)
    );

    deq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_in.data.push_value),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Fill count carries the low five bits of the word count
    assign cnt_ext     = (CW+FILL_W)'(count);
    assign cnt_inc_ext = (CW+FILL_W)'(count) + (CW+FILL_W)'(1);
    assign fill_now    = cnt_ext[FILL_W-1:0];
    assign fill_inc    = cnt_inc_ext[FILL_W-1:0];

    // Walk from the front: offset zero at the start, then one past the word shown
    assign walk_off  = (r_state == S_LIST) ? r_idx + AW'(1) : '0;
    assign walk_last = ((CW'(r_idx) + CW'(1)) == count);

    // Output register may load when empty or when its word leaves this cycle
    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        in_ready  = 1'b0;
        out_load  = 1'b0;
        n_out     = '{status: ST_OK, value_out: '0, last: 1'b1, fill_count: fill_now};
        ptr_cmd   = '0;
        mem_we    = 1'b0;
        mem_waddr = push_rear_slot;
        mem_re    = 1'b0;
        mem_raddr = walk_slot;

        case (r_state)
            S_IDLE: begin
                in_ready = out_free;
                if (i_in.valid && out_free) begin
                    case (i_in.data.func)
                        FN_PUSH_FRONT: begin
                            out_load = 1'b1;
                            if (ptr_stat.full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                mem_we             = 1'b1;
                                mem_waddr          = push_front_slot;
                                ptr_cmd.push_front = 1'b1;
                                n_out.fill_count   = fill_inc;
                            end
                        end
                        FN_PUSH_REAR: begin
                            out_load = 1'b1;
                            if (ptr_stat.full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                mem_we            = 1'b1;
                                mem_waddr         = push_rear_slot;
                                ptr_cmd.push_rear = 1'b1;
                                n_out.fill_count  = fill_inc;
                            end
                        end
                        FN_POP_FRONT: begin
                            if (ptr_stat.empty) begin
                                out_load     = 1'b1;
                                n_out.status = ST_EMPTY;
                            end else begin
                                mem_re            = 1'b1;
                                mem_raddr         = head;
                                ptr_cmd.pop_front = 1'b1;
                                n_state           = S_POP;
                            end
                        end
                        FN_POP_REAR: begin
                            if (ptr_stat.empty) begin
                                out_load     = 1'b1;
                                n_out.status = ST_EMPTY;
                            end else begin
                                mem_re           = 1'b1;
                                mem_raddr        = pop_rear_slot;
                                ptr_cmd.pop_rear = 1'b1;
                                n_state          = S_POP;
                            end
                        end
                        FN_LIST: begin
                            if (ptr_stat.empty) begin
                                out_load     = 1'b1;
                                n_out.status = ST_EMPTY;
                            end else begin
                                mem_re  = 1'b1;
                                n_idx   = '0;
                                n_state = S_LIST;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                // Count already reflects the removal
                if (out_free) begin
                    out_load        = 1'b1;
                    n_out.value_out = mem_rdata;
                    n_state         = S_IDLE;
                end
            end
            S_LIST: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    n_out.value_out = mem_rdata;
                    n_out.last      = walk_last;
                    if (walk_last) begin
                        n_state = S_IDLE;
                    end else begin
                        mem_re = 1'b1;
                        n_idx  = r_idx + AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule
